FILE: rtl/edidbb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EDID base block package
// Widths, fixed layout bytes and the monitor name for the EDID block server.
// ----------------------------------------------------------------------------
package edidbb_pkg;

  localparam int IMG_WIDTH  = 8;
  localparam int IMG_DEPTH  = 128;
  localparam int ADDR_W     = $clog2(IMG_DEPTH);

  localparam int VENDOR_W   = 15;
  localparam int COUNT_W    = 2;
  localparam int SIZE_W     = 12;
  localparam int RATE_W     = 8;
  localparam int CFG_DATA_W = 15;
  localparam int CFG_IDX_W  = 3;

  localparam int TOTAL_W    = 13;
  localparam int BLANK_W    = 7;
  localparam int AREA_W     = 2 * TOTAL_W;
  localparam int PROD_W     = AREA_W + RATE_W;
  localparam int PCLK_W     = 16;

  // divide by 10000 = 16 * 625: drop four bits, then multiply by
  // ceil(2^39 / 625); exact for every 30-bit dividend
  localparam int                 DIV_SHIFT    = 4;
  localparam int                 QUOT_IN_W    = PROD_W - DIV_SHIFT;
  localparam int                 RECIP_W      = 30;
  localparam int                 RECIP_SHIFT  = 39;
  localparam int                 RECIP_PROD_W = QUOT_IN_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP        = 30'd879609303;

  localparam logic [ADDR_W-1:0] DESC_BASE = 7'd54;
  localparam logic [ADDR_W-1:0] DESC_END  = 7'd126;
  localparam logic [ADDR_W-1:0] LAST_ADDR = 7'd127;
  localparam int                DESC_LEN  = 18;

  localparam logic [7:0] TAG_NAME    = 8'hFC;
  localparam logic [7:0] TAG_DUMMY   = 8'h10;
  localparam logic [7:0] HSYNC_OFS   = 8'd8;
  localparam logic [7:0] HSYNC_WIDTH = 8'd32;
  localparam logic [7:0] VSYNC_PACK  = 8'h22;
  localparam logic [7:0] SIZE_H_MM   = 8'd119;
  localparam logic [7:0] SIZE_V_MM   = 8'd66;
  localparam logic [7:0] SYNC_FLAGS  = 8'h1A;

  localparam logic [7:0] NAME_ROM [13] = '{
    8'h56, 8'h52, 8'h20, 8'h44, 8'h49, 8'h53, 8'h50,
    8'h4C, 8'h41, 8'h59, 8'h0A, 8'h20, 8'h20
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VENDOR   = 3'd0,
    REG_COUNT    = 3'd1,
    REG_W0       = 3'd2,
    REG_H0       = 3'd3,
    REG_R0       = 3'd4,
    REG_W1       = 3'd5,
    REG_H1       = 3'd6,
    REG_R1       = 3'd7
  } cfg_reg_t;

  // hblank = 40 + 32 - (w + 40) mod 32
  function automatic logic [BLANK_W-1:0] hblank_of(input logic [SIZE_W-1:0] w);
    logic [4:0] lo;
    lo = w[4:0] + 5'd8;
    return 7'd72 - {2'b00, lo};
  endfunction

  // vblank = 52 + 32 - (h + 52) mod 32
  function automatic logic [BLANK_W-1:0] vblank_of(input logic [SIZE_W-1:0] h);
    logic [4:0] lo;
    lo = h[4:0] + 5'd20;
    return 7'd84 - {2'b00, lo};
  endfunction

endpackage

FILE: rtl/edidbb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module edidbb_ram import edidbb_pkg::*; #(
  parameter int WIDTH = IMG_WIDTH,
  parameter int DEPTH = IMG_DEPTH,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/edid_base_block_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EDID base block generator
// Serves the 128-byte EDID 1.3 base block one byte per address read.
//
// Input channel: in_valid / in_ready carry byte_address. Output channel:
// out_valid / out_ready carry byte_value, one result per transfer, in order.
// Configuration: cfg_write with cfg_index and cfg_data writes one register.
//
// The whole block is kept as an image in a 128 x 8 RAM. After reset and
// after every configuration write the image is rebuilt: per mode ST_AREA
// forms htotal * vtotal, ST_PROD the rate product and ST_DIV the division
// by 10000 as a reciprocal multiplication, then ST_FILL writes the image
// with the running checksum landing at byte 127. During a rebuild in_ready
// stays low; a write during a rebuild restarts it.
//
// Once built, one address is taken per cycle while the output stage has
// room. The byte goes through the RAM read register and then the output
// register before it is presented, and can leave at the following edge.
// A two-entry output stage absorbs a stalled receiver; in_ready drops only
// once both entries and the read in flight would be full.
// ----------------------------------------------------------------------------
module edid_base_block_generator import edidbb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ADDR_W-1:0]     byte_address,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            byte_value
);

  typedef enum logic [2:0] {
    ST_AREA,
    ST_PROD,
    ST_DIV,
    ST_FILL,
    ST_READY
  } state_t;

  state_t state;

  logic [VENDOR_W-1:0] vendor_code;
  logic [COUNT_W-1:0]  mode_count;
  logic [SIZE_W-1:0]   mode_w [2];
  logic [SIZE_W-1:0]   mode_h [2];
  logic [RATE_W-1:0]   mode_r [2];
  logic [PCLK_W-1:0]   pclk   [2];

  logic                mode_sel;
  logic [AREA_W-1:0]   area;
  logic [PROD_W-1:0]   prod;
  logic [ADDR_W-1:0]   fill_addr;
  logic [1:0]          desc_idx;
  logic [4:0]          desc_off;
  logic [7:0]          sum;

  // calculation unit
  logic [SIZE_W-1:0]       calc_w, calc_h;
  logic [TOTAL_W-1:0]      htotal, vtotal;
  logic [RECIP_PROD_W-1:0] recip_prod;
  logic [PCLK_W-1:0]       pclk_calc;

  always_comb begin
    calc_w     = mode_w[mode_sel];
    calc_h     = mode_h[mode_sel];
    htotal     = {1'b0, calc_w} + {{(TOTAL_W-BLANK_W){1'b0}}, hblank_of(calc_w)};
    vtotal     = {1'b0, calc_h} + {{(TOTAL_W-BLANK_W){1'b0}}, vblank_of(calc_h)};
    recip_prod = RECIP_PROD_W'(prod[PROD_W-1:DIV_SHIFT]) * RECIP_PROD_W'(RECIP);
    pclk_calc  = recip_prod[RECIP_SHIFT +: PCLK_W];
  end

  // image byte generation
  logic               k;
  logic               k_active;
  logic [SIZE_W-1:0]  dw, dh;
  logic [BLANK_W-1:0] dhb, dvb;
  logic [PCLK_W-1:0]  dclk;
  logic [3:0]         name_idx;
  logic [7:0]         gen_byte;
  logic [7:0]         head_byte;
  logic [7:0]         desc_byte;

  always_comb begin
    k         = desc_idx[1];
    k_active  = k ? (mode_count[1] == 1'b1) : (mode_count != '0);
    dw        = mode_w[k];
    dh        = mode_h[k];
    dhb       = hblank_of(dw);
    dvb       = vblank_of(dh);
    dclk      = pclk[k];
    name_idx  = 4'(desc_off - 5'd5);

    unique case (fill_addr)
      7'd1, 7'd2, 7'd3, 7'd4, 7'd5, 7'd6: head_byte = 8'hFF;
      7'd8:  head_byte = {1'b0, vendor_code[14:8]};
      7'd9:  head_byte = vendor_code[7:0];
      7'd10: head_byte = 8'h01;
      7'd18: head_byte = 8'h01;
      7'd19: head_byte = 8'h03;
      7'd20: head_byte = 8'h80;
      7'd23: head_byte = 8'h78;
      7'd24: head_byte = 8'hE2;
      default: begin
        head_byte = (fill_addr >= 7'd38 && fill_addr < DESC_BASE) ? 8'h01 : 8'h00;
      end
    endcase

    desc_byte = 8'h00;
    if (!k_active) begin
      if (desc_off == 5'd3) begin
        desc_byte = TAG_DUMMY;
      end
    end else if (desc_idx[0]) begin
      if (desc_off == 5'd3) begin
        desc_byte = TAG_NAME;
      end else if (desc_off >= 5'd5) begin
        desc_byte = NAME_ROM[name_idx];
      end
    end else begin
      case (desc_off)
        5'd0:  desc_byte = dclk[7:0];
        5'd1:  desc_byte = dclk[15:8];
        5'd2:  desc_byte = dw[7:0];
        5'd3:  desc_byte = {1'b0, dhb};
        5'd4:  desc_byte = {dw[11:8], 4'h0};
        5'd5:  desc_byte = dh[7:0];
        5'd6:  desc_byte = {1'b0, dvb};
        5'd7:  desc_byte = {dh[11:8], 4'h0};
        5'd8:  desc_byte = HSYNC_OFS;
        5'd9:  desc_byte = HSYNC_WIDTH;
        5'd10: desc_byte = VSYNC_PACK;
        5'd11: desc_byte = 8'h0C;
        5'd12: desc_byte = SIZE_H_MM;
        5'd13: desc_byte = SIZE_V_MM;
        5'd17: desc_byte = SYNC_FLAGS;
        default: desc_byte = 8'h00;
      endcase
    end

    gen_byte = (fill_addr >= DESC_BASE && fill_addr < DESC_END) ? desc_byte : head_byte;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vendor_code <= '0;
      mode_count  <= '0;
      mode_w[0]   <= 12'd1920;
      mode_h[0]   <= 12'd1080;
      mode_r[0]   <= 8'd60;
      mode_w[1]   <= 12'd1920;
      mode_h[1]   <= 12'd1080;
      mode_r[1]   <= 8'd60;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_VENDOR: vendor_code <= cfg_data[VENDOR_W-1:0];
        REG_COUNT:  mode_count  <= cfg_data[COUNT_W-1:0];
        REG_W0:     mode_w[0]   <= cfg_data[SIZE_W-1:0];
        REG_H0:     mode_h[0]   <= cfg_data[SIZE_W-1:0];
        REG_R0:     mode_r[0]   <= cfg_data[RATE_W-1:0];
        REG_W1:     mode_w[1]   <= cfg_data[SIZE_W-1:0];
        REG_H1:     mode_h[1]   <= cfg_data[SIZE_W-1:0];
        REG_R1:     mode_r[1]   <= cfg_data[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // rebuild sequencer
  logic             ram_we;
  logic [7:0]       ram_wdata;

  always_comb begin
    ram_we    = (state == ST_FILL);
    ram_wdata = (fill_addr == LAST_ADDR) ? 8'(8'd0 - sum) : gen_byte;
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      state    <= ST_AREA;
      mode_sel <= 1'b0;
    end else begin
      unique case (state)
        ST_AREA: begin
          area  <= AREA_W'(htotal) * AREA_W'(vtotal);
          state <= ST_PROD;
        end
        ST_PROD: begin
          prod  <= PROD_W'(area) * PROD_W'(mode_r[mode_sel]);
          state <= ST_DIV;
        end
        ST_DIV: begin
          pclk[mode_sel] <= pclk_calc;
          if (mode_sel) begin
            fill_addr <= '0;
            desc_idx  <= '0;
            desc_off  <= '0;
            sum       <= '0;
            state     <= ST_FILL;
          end else begin
            mode_sel <= 1'b1;
            state    <= ST_AREA;
          end
        end
        ST_FILL: begin
          sum       <= sum + gen_byte;
          fill_addr <= fill_addr + 7'd1;
          if (fill_addr >= DESC_BASE) begin
            if (desc_off == 5'(DESC_LEN - 1)) begin
              desc_off <= '0;
              desc_idx <= desc_idx + 2'd1;
            end else begin
              desc_off <= desc_off + 5'd1;
            end
          end
          if (fill_addr == LAST_ADDR) begin
            state <= ST_READY;
          end
        end
        ST_READY: ;
        default: state <= ST_AREA;
      endcase
    end
  end

  // read path and output stage
  logic       in_xfer;
  logic       pop;
  logic       rd_pend;
  logic [7:0] rd_data;
  logic       skid_valid;
  logic [7:0] skid_data;
  logic [1:0] occ;

  always_comb begin
    pop      = out_valid && out_ready;
    occ      = {1'b0, out_valid} + {1'b0, skid_valid} + {1'b0, rd_pend};
    in_ready = (state == ST_READY) && ((occ < 2'd2) || (pop && occ == 2'd2));
    in_xfer  = in_valid && in_ready;
  end

  edidbb_ram #(
    .WIDTH (IMG_WIDTH),
    .DEPTH (IMG_DEPTH)
  ) u_image (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (fill_addr),
    .wr_data (ram_wdata),
    .rd_en   (in_xfer),
    .rd_addr (byte_address),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend    <= 1'b0;
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      rd_pend <= in_xfer;
      if (!out_valid || pop) begin
        if (skid_valid) begin
          byte_value <= skid_data;
          out_valid  <= 1'b1;
          skid_valid <= rd_pend;
          skid_data  <= rd_data;
        end else if (rd_pend) begin
          byte_value <= rd_data;
          out_valid  <= 1'b1;
        end else begin
          out_valid <= 1'b0;
        end
      end else if (rd_pend) begin
        skid_data  <= rd_data;
        skid_valid <= 1'b1;
      end
    end
  end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EDID base block generator testbench
// Reads bytes of the served EDID image under several register settings and
// compares every returned byte with a locally built copy of the 128-byte
// block. Both channels idle at random outside the steady phases; one phase
// stalls the receiver long enough to fill the block and stall its input.
// ----------------------------------------------------------------------------
module testbench;
  import edidbb_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 10;
  localparam int HOLD_OFF       = 300;

  localparam logic [7:0] MONITOR_NAME [13] = '{
    8'h56, 8'h52, 8'h20, 8'h44, 8'h49, 8'h53, 8'h50,
    8'h4C, 8'h41, 8'h59, 8'h0A, 8'h20, 8'h20
  };

  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  cfg_write    = 1'b0;
  cfg_reg_t              cfg_index    = REG_VENDOR;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;
  logic                  in_valid     = 1'b0;
  logic                  in_ready;
  logic [ADDR_W-1:0]     byte_address = '0;
  logic                  out_valid;
  logic                  out_ready    = 1'b0;
  logic [7:0]            byte_value;

  logic [VENDOR_W-1:0] vendor_code = '0;
  logic [COUNT_W-1:0]  mode_count  = '0;
  logic [SIZE_W-1:0]   mode_width  [2] = '{12'd1920, 12'd1920};
  logic [SIZE_W-1:0]   mode_height [2] = '{12'd1080, 12'd1080};
  logic [RATE_W-1:0]   mode_rate   [2] = '{8'd60, 8'd60};

  logic [7:0]        edid_image [128];
  logic [7:0]        expected_bytes [$];
  logic [ADDR_W-1:0] expected_addrs [$];

  int mismatch_count = 0;
  int quiet_cycles   = 0;
  int hold_request   = 0;
  int stall_left     = 0;
  bit steady         = 1'b0;

  edid_base_block_generator dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .byte_address (byte_address),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .byte_value   (byte_value)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void rebuild_edid_image();
    int unsigned     modes;
    int unsigned     base;
    int unsigned     w;
    int unsigned     h;
    int unsigned     hblank;
    int unsigned     vblank;
    longint unsigned pixels;
    logic [15:0]     pclk;
    logic [7:0]      sum;
    for (int i = 0; i < 128; i++) edid_image[i] = 8'h00;
    for (int i = 1; i < 7; i++) edid_image[i] = 8'hFF;
    edid_image[8]  = {1'b0, vendor_code[14:8]};
    edid_image[9]  = vendor_code[7:0];
    edid_image[10] = 8'd1;
    edid_image[18] = 8'd1;
    edid_image[19] = 8'd3;
    edid_image[20] = 8'h80;
    edid_image[23] = 8'h78;
    edid_image[24] = 8'hE2;
    for (int i = 38; i < 54; i++) edid_image[i] = 8'h01;
    for (int k = 0; k < 4; k++) edid_image[57 + 18 * k] = TAG_DUMMY;
    modes = (mode_count > 2) ? 2 : mode_count;
    for (int k = 0; k < modes; k++) begin
      base = 54 + 36 * k;
      for (int i = 0; i < 36; i++) edid_image[base + i] = 8'h00;
      w      = mode_width[k];
      h      = mode_height[k];
      hblank = 72 - (w + 40) % 32;
      vblank = 84 - (h + 52) % 32;
      pixels = mode_rate[k];
      pixels = pixels * (w + hblank) * (h + vblank);
      pclk   = 16'(pixels / 10000);
      edid_image[base]      = pclk[7:0];
      edid_image[base + 1]  = pclk[15:8];
      edid_image[base + 2]  = w[7:0];
      edid_image[base + 3]  = hblank[7:0];
      edid_image[base + 4]  = {w[11:8], hblank[11:8]};
      edid_image[base + 5]  = h[7:0];
      edid_image[base + 6]  = vblank[7:0];
      edid_image[base + 7]  = {h[11:8], vblank[11:8]};
      edid_image[base + 8]  = 8'd8;
      edid_image[base + 9]  = 8'd32;
      edid_image[base + 10] = 8'h22;
      edid_image[base + 11] = 8'h0C;
      edid_image[base + 12] = 8'd119;
      edid_image[base + 13] = 8'd66;
      edid_image[base + 17] = 8'h1A;
      edid_image[base + 21] = TAG_NAME;
      for (int i = 0; i < 13; i++) edid_image[base + 23 + i] = MONITOR_NAME[i];
    end
    sum = 8'h00;
    for (int i = 0; i < 127; i++) sum = sum + edid_image[i];
    edid_image[127] = 8'h00 - sum;
  endfunction

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_VENDOR: vendor_code    = data[VENDOR_W-1:0];
      REG_COUNT:  mode_count     = data[COUNT_W-1:0];
      REG_W0:     mode_width[0]  = data[SIZE_W-1:0];
      REG_H0:     mode_height[0] = data[SIZE_W-1:0];
      REG_R0:     mode_rate[0]   = data[RATE_W-1:0];
      REG_W1:     mode_width[1]  = data[SIZE_W-1:0];
      REG_H1:     mode_height[1] = data[SIZE_W-1:0];
      REG_R1:     mode_rate[1]   = data[RATE_W-1:0];
      default: ;
    endcase
    rebuild_edid_image();
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_address(input logic [ADDR_W-1:0] addr);
    if (!steady && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    byte_address <= addr;
    do @(posedge clk); while (in_ready !== 1'b1);
    expected_bytes.push_back(edid_image[addr]);
    expected_addrs.push_back(addr);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(negedge clk);
  endtask

  task automatic test_reset_defaults();
    logic [ADDR_W-1:0] picks [8] = '{7'd0, 7'd1, 7'd7, 7'd8, 7'd9, 7'd10, 7'd57, 7'd127};
    foreach (picks[i]) send_address(picks[i]);
    drain_results();
  endtask

  // saturated mode count, clock overflow on the first mode, zeros on the second
  task automatic test_extreme_modes();
    logic [ADDR_W-1:0] picks [12] = '{7'd54, 7'd55, 7'd56, 7'd57, 7'd58, 7'd61,
                                      7'd72, 7'd75, 7'd90, 7'd108, 7'd126, 7'd127};
    write_reg(REG_VENDOR, 15'h7FFF);
    write_reg(REG_COUNT,  15'h7FFF);
    write_reg(REG_W0,     15'h7FFF);
    write_reg(REG_H0,     15'h0FFF);
    write_reg(REG_R0,     15'h00FF);
    write_reg(REG_W1,     15'h0000);
    write_reg(REG_H1,     15'h0000);
    write_reg(REG_R1,     15'h0000);
    foreach (picks[i]) send_address(picks[i]);
    drain_results();
  endtask

  task automatic test_single_zero_mode();
    logic [ADDR_W-1:0] picks [7] = '{7'd54, 7'd58, 7'd71, 7'd72, 7'd76, 7'd90, 7'd127};
    write_reg(REG_VENDOR, 15'h0000);
    write_reg(REG_COUNT,  15'h0001);
    write_reg(REG_W0,     15'h7000);
    write_reg(REG_H0,     15'h0000);
    write_reg(REG_R0,     15'h7F00);
    foreach (picks[i]) send_address(picks[i]);
    drain_results();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 6; phase++) begin
      write_reg(REG_VENDOR, CFG_DATA_W'($urandom));
      write_reg(REG_COUNT,  CFG_DATA_W'($urandom));
      write_reg(REG_W0,     CFG_DATA_W'($urandom));
      write_reg(REG_H0,     CFG_DATA_W'($urandom));
      write_reg(REG_R0,     CFG_DATA_W'($urandom));
      write_reg(REG_W1,     CFG_DATA_W'($urandom));
      write_reg(REG_H1,     CFG_DATA_W'($urandom));
      write_reg(REG_R1,     CFG_DATA_W'($urandom));
      repeat (65) send_address(ADDR_W'($urandom_range(127)));
      drain_results();
    end
  endtask

  task automatic test_steady_stream();
    steady = 1'b1;
    repeat (50) send_address(ADDR_W'($urandom_range(127)));
    drain_results();
    steady = 1'b0;
  endtask

  // hold the receiver off while the sender keeps offering back to back
  task automatic test_output_backpressure();
    steady       = 1'b1;
    hold_request = HOLD_OFF;
    repeat (40) send_address(ADDR_W'($urandom_range(127)));
    drain_results();
    steady = 1'b0;
  endtask

  always @(negedge clk) begin
    if (hold_request > 0) begin
      stall_left   = hold_request;
      hold_request = 0;
    end
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= 38);
    end
  end

  always @(posedge clk) begin
    logic [7:0]        want;
    logic [ADDR_W-1:0] addr;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: byte_value transfer with none expected, actual %h", $time, byte_value);
        mismatch_count++;
      end else begin
        want = expected_bytes.pop_front();
        addr = expected_addrs.pop_front();
        if (byte_value !== want) begin
          $display("%0t: byte_address %0d byte_value expected %h actual %h",
                   $time, addr, want, byte_value);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no transfer for %0d cycles", $time, quiet_cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rebuild_edid_image();
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_extreme_modes();
    test_single_zero_mode();
    test_random_traffic();
    test_steady_stream();
    test_output_backpressure();
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && expected_bytes.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
